@@ rtl/core/dqc_pkg.sv @@
// dqc_pkg: shared constants, codes and bundle types of the depth correction pipeline
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package dqc_pkg;

  // number formats
  localparam int FRAC_BITS = 32;
  localparam int COEF_W    = 64;
  localparam int HALF_W    = COEF_W / 2;
  localparam int SMP_W     = 16;
  localparam int IDX_W     = 12;
  localparam logic [COEF_W-1:0] ONE = 64'd1 << FRAC_BITS;

  // valid index window
  localparam logic [SMP_W-1:0] DEPTH_MAX = 16'd4000;
  localparam logic [SMP_W-1:0] DEPTH_MIN = 16'd100;

  // divide by ten through a reciprocal, exact for every 16-bit sample
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP10 = 17'd52429;
  localparam int RECIP_SHIFT = 19;
  localparam int SCALED_W    = SMP_W + RECIP_W;

  // datapath widths
  localparam int PROD_W     = 2 * COEF_W;
  localparam int P4_W       = PROD_W + 2;
  localparam int DELTA_W    = PROD_W + 4;
  localparam int ROOT_W     = DELTA_W / 2;
  localparam int REM_W      = ROOT_W + 1;
  localparam int NUM_W      = ROOT_W + 1;
  localparam int DEN_W      = COEF_W + 1;
  localparam int QUO_W      = 16;
  localparam int DSH_W      = DEN_W + QUO_W - 1;
  localparam int SAT_W      = DEN_W + QUO_W;
  localparam int RES_W      = 16;
  localparam int MUL10_W    = RES_W + 4;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = QUO_W;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    REG_QUAD = 2'd0,
    REG_LIN  = 2'd1,
    REG_OFF  = 2'd2,
    REG_UNIT = 2'd3
  } reg_idx_t;

  // how the final result of a pixel is formed
  typedef enum logic [1:0] {
    KIND_ROOT = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_PASS = 2'd2,
    KIND_SAT  = 2'd3
  } kind_t;

  // per-pixel data that travels beside the arithmetic
  typedef struct packed {
    logic              last;
    kind_t             kind;
    logic [IDX_W-1:0]  d;
    logic [COEF_W-1:0] am;
    logic              an;
    logic [COEF_W-1:0] bm;
    logic              bn;
  } side_t;

  // square root cell state
  typedef struct packed {
    logic [DELTA_W-1:0] x;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_t;

  // division cell state
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DSH_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

@@ rtl/core/dqc_ifs.sv @@
// dqc_ifs: valid/ready stream interfaces for depth pixels in and corrected pixels out
// depends on dqc_pkg
`timescale 1ns / 1ps

interface dqc_in_if import dqc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] depth_sample;
  logic             last_in;

  modport source(output valid, output depth_sample, output last_in, input ready);
  modport sink(input valid, input depth_sample, input last_in, output ready);
endinterface

interface dqc_out_if import dqc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] corrected_depth;
  logic             last_out;

  modport source(output valid, output corrected_depth, output last_out, input ready);
  modport sink(input valid, input corrected_depth, input last_out, output ready);
endinterface

@@ rtl/core/dqc_front.sv @@
// dqc_front: six-stage front end, index, coefficient magnitudes, products and delta
// depends on dqc_pkg; feeds the first square root cell
`timescale 1ns / 1ps

module dqc_front import dqc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [SMP_W-1:0]  smp,
  input  logic              last,
  input  logic [COEF_W-1:0] quad,
  input  logic [COEF_W-1:0] lin,
  input  logic [COEF_W-1:0] off,
  input  logic              unit,
  output logic              v_o,
  output side_t             side_o,
  output sqrt_t             sq_o
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1 data
  logic [SCALED_W-1:0] prod1_r;
  logic [SMP_W-1:0]    smp1_r;
  logic                last1_r;

  // stage 2 data
  logic              last2_r;
  kind_t             kind2_r;
  logic [IDX_W-1:0]  d2_r;
  logic [COEF_W-1:0] am2_r, lm2_r, om2_r;
  logic              an2_r, ln2_r, on2_r;

  // stage 3..5 data
  side_t             side3_r, side4_r, side5_r;
  logic [COEF_W-1:0] cm3_r;
  logic              cn3_r;
  logic [COEF_W-1:0] pbll4_r, pblh4_r, pbhh4_r;
  logic [COEF_W-1:0] pall4_r, palh4_r, pahl4_r, pahh4_r;
  logic              add4_r, add5_r;
  logic [PROD_W-1:0] b2_5_r;
  logic [P4_W-1:0]   p5_r;

  // stage 6 outputs
  side_t side6_r;
  sqrt_t sq6_r;

  // combinational helpers
  logic [SMP_W-1:0]  d16;
  logic              bad;
  logic [COEF_W-1:0] bm, cm, ds;
  logic              bn, cn;
  logic [PROD_W-1:0] b2_sum, ac_sum;
  logic [DELTA_W-1:0] b2_ext, p_ext, delta;
  kind_t             kind6;
  side_t             side6;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // stage 2: index and range, sign and magnitude of coefficients
  always_comb begin
    d16 = unit ? {{(SMP_W-(SCALED_W-RECIP_SHIFT)){1'b0}}, prod1_r[SCALED_W-1:RECIP_SHIFT]}
               : smp1_r;
    bad = (d16 > DEPTH_MAX) || (d16 < DEPTH_MIN);
  end

  // stage 3: b = lin + 1 and c - d in sign and magnitude
  always_comb begin
    ds = {{(COEF_W-IDX_W){1'b0}}, d2_r} << FRAC_BITS;
    if (!ln2_r) begin
      bm = lm2_r + ONE;
      bn = 1'b0;
    end else if (lm2_r >= ONE) begin
      bm = lm2_r - ONE;
      bn = (bm != '0);
    end else begin
      bm = ONE - lm2_r;
      bn = 1'b0;
    end
    if (!on2_r) begin
      if (om2_r >= ds) begin
        cm = om2_r - ds;
        cn = 1'b0;
      end else begin
        cm = ds - om2_r;
        cn = 1'b1;
      end
    end else begin
      cm = om2_r + ds;
      cn = 1'b1;
    end
  end

  // stage 5: sum the partial products
  always_comb begin
    b2_sum = {pbhh4_r, {COEF_W{1'b0}}}
           + {{(HALF_W-1){1'b0}}, pblh4_r, {(HALF_W+1){1'b0}}}
           + {{COEF_W{1'b0}}, pbll4_r};
    ac_sum = {pahh4_r, {COEF_W{1'b0}}}
           + {{HALF_W{1'b0}}, palh4_r, {HALF_W{1'b0}}}
           + {{HALF_W{1'b0}}, pahl4_r, {HALF_W{1'b0}}}
           + {{COEF_W{1'b0}}, pall4_r};
  end

  // stage 6: delta = b^2 -/+ 4ac
  always_comb begin
    b2_ext = {{(DELTA_W-PROD_W){1'b0}}, b2_5_r};
    p_ext  = {{(DELTA_W-P4_W){1'b0}}, p5_r};
    kind6  = side5_r.kind;
    if (add5_r) begin
      delta = b2_ext + p_ext;
      if (delta == '0 && kind6 == KIND_ROOT) kind6 = KIND_PASS;
    end else begin
      delta = b2_ext - p_ext;
      if (b2_ext <= p_ext && kind6 == KIND_ROOT) kind6 = KIND_PASS;
    end
    side6      = side5_r;
    side6.kind = kind6;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= SCALED_W'(smp) * SCALED_W'(RECIP10);
      smp1_r  <= smp;
      last1_r <= last;

      last2_r <= last1_r;
      kind2_r <= bad ? KIND_ZERO : ((quad == '0) ? KIND_PASS : KIND_ROOT);
      d2_r    <= d16[IDX_W-1:0];
      an2_r   <= quad[COEF_W-1];
      am2_r   <= quad[COEF_W-1] ? (~quad + 64'd1) : quad;
      ln2_r   <= lin[COEF_W-1];
      lm2_r   <= lin[COEF_W-1] ? (~lin + 64'd1) : lin;
      on2_r   <= off[COEF_W-1];
      om2_r   <= off[COEF_W-1] ? (~off + 64'd1) : off;

      side3_r.last <= last2_r;
      side3_r.kind <= kind2_r;
      side3_r.d    <= d2_r;
      side3_r.am   <= am2_r;
      side3_r.an   <= an2_r;
      side3_r.bm   <= bm;
      side3_r.bn   <= bn;
      cm3_r        <= cm;
      cn3_r        <= cn;

      side4_r <= side3_r;
      pbll4_r <= side3_r.bm[HALF_W-1:0] * side3_r.bm[HALF_W-1:0];
      pblh4_r <= side3_r.bm[HALF_W-1:0] * side3_r.bm[COEF_W-1:HALF_W];
      pbhh4_r <= side3_r.bm[COEF_W-1:HALF_W] * side3_r.bm[COEF_W-1:HALF_W];
      pall4_r <= side3_r.am[HALF_W-1:0] * cm3_r[HALF_W-1:0];
      palh4_r <= side3_r.am[HALF_W-1:0] * cm3_r[COEF_W-1:HALF_W];
      pahl4_r <= side3_r.am[COEF_W-1:HALF_W] * cm3_r[HALF_W-1:0];
      pahh4_r <= side3_r.am[COEF_W-1:HALF_W] * cm3_r[COEF_W-1:HALF_W];
      add4_r  <= (cm3_r == '0) || (side3_r.an != cn3_r);

      side5_r <= side4_r;
      b2_5_r  <= b2_sum;
      p5_r    <= {ac_sum, 2'b00};
      add5_r  <= add4_r;

      side6_r    <= side6;
      sq6_r.x    <= delta;
      sq6_r.rem  <= '0;
      sq6_r.root <= '0;
    end
  end

  assign v_o    = v6_r;
  assign side_o = side6_r;
  assign sq_o   = sq6_r;

endmodule

@@ rtl/core/dqc_sqrt_cell.sv @@
// dqc_sqrt_cell: one digit of a restoring square root, one root bit per cell
// depends on dqc_pkg; chained by the top level
`timescale 1ns / 1ps

module dqc_sqrt_cell import dqc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_i,
  input  side_t side_i,
  input  sqrt_t sq_i,
  output logic  v_o,
  output side_t side_o,
  output sqrt_t sq_o
);

  logic [REM_W+1:0] shifted, trial, diff;
  logic             take;
  sqrt_t            sq_nxt;
  logic             v_r;
  side_t            side_r;
  sqrt_t            sq_r;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    shifted     = {sq_i.rem, sq_i.x[DELTA_W-1 -: 2]};
    trial       = {1'b0, sq_i.root, 2'b01};
    diff        = shifted - trial;
    take        = (shifted >= trial);
    sq_nxt.rem  = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    sq_nxt.root = {sq_i.root[ROOT_W-2:0], take};
    sq_nxt.x    = {sq_i.x[DELTA_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      sq_r   <= sq_nxt;
    end
  end

  assign v_o    = v_r;
  assign side_o = side_r;
  assign sq_o   = sq_r;

endmodule

@@ rtl/core/dqc_div_cell.sv @@
// dqc_div_cell: one step of a restoring division, one quotient bit per cell
// depends on dqc_pkg; chained by the top level
`timescale 1ns / 1ps

module dqc_div_cell import dqc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_i,
  input  side_t side_i,
  input  div_t  dv_i,
  output logic  v_o,
  output side_t side_o,
  output div_t  dv_o
);

  logic [DSH_W-1:0] num_ext, diff;
  logic             ge;
  div_t             dv_nxt;
  logic             v_r;
  side_t            side_r;
  div_t             dv_r;

  // compare against the shifted divisor, subtract when it fits
  always_comb begin
    num_ext    = {{(DSH_W-NUM_W){1'b0}}, dv_i.num};
    diff       = num_ext - dv_i.dsh;
    ge         = (num_ext >= dv_i.dsh);
    dv_nxt.num = ge ? diff[NUM_W-1:0] : dv_i.num;
    dv_nxt.dsh = dv_i.dsh >> 1;
    dv_nxt.quo = {dv_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      dv_r   <= dv_nxt;
    end
  end

  assign v_o    = v_r;
  assign side_o = side_r;
  assign dv_o   = dv_r;

endmodule

@@ rtl/core/depth_quadratic_correction_top.sv @@
// Depth quadratic correction: takes one 16-bit depth pixel per clock and returns the
// corrected pixel in order, one result per pixel, last flag
// carried along. The pipeline is 6 front stages (index, coefficient magnitudes, 32x32
// partial products, delta), a chain of 66 square root cells (one root bit each), one
// root/sign stage, 16 division cells (one quotient bit each) and a 2-entry output
// buffer; throughput is one pixel per cycle, and the whole pipeline holds only while
// that buffer is full. Coefficients are written over the APB port at byte address
// 8*index and must only change while no pixel is in flight.
// depends on dqc_pkg, dqc_ifs, dqc_front, dqc_sqrt_cell, dqc_div_cell
`timescale 1ns / 1ps

module depth_quadratic_correction_top import dqc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dqc_in_if.sink            in_chan,
  dqc_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [COEF_W-1:0] quad_r, lin_r, off_r;
  logic              unit_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // pipeline control
  logic en;

  // square root chain
  logic  sq_v    [0:SQRT_CELLS];
  side_t sq_side [0:SQRT_CELLS];
  sqrt_t sq_bus  [0:SQRT_CELLS];

  // division chain
  logic  dv_v    [0:DIV_CELLS];
  side_t dv_side [0:DIV_CELLS];
  div_t  dv_bus  [0:DIV_CELLS];

  // root and sign stage
  logic [NUM_W-1:0]  nval;
  logic              nneg;
  logic [NUM_W-1:0]  s_ext, b_ext;
  logic [SAT_W-1:0]  sat_lim;
  side_t             pside;
  logic              pv_r;
  side_t             pside_r;
  div_t              pdiv_r;

  // final result and output buffer
  logic [RES_W-1:0]   res16, res_fin;
  logic [MUL10_W-1:0] res10;
  logic               push, pop;
  logic [1:0]         cnt_r;
  logic               full_r;
  logic [RES_W-1:0]   d0_r, d1_r;
  logic               l0_r, l1_r;

  // apb register writes
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= '0;
      lin_r  <= '0;
      off_r  <= '0;
      unit_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_QUAD: quad_r <= pwdata;
        REG_LIN:  lin_r  <= pwdata;
        REG_OFF:  off_r  <= pwdata;
        REG_UNIT: unit_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // apb read mux
  always_comb begin
    case (cfg_idx)
      REG_QUAD: prdata = quad_r;
      REG_LIN:  prdata = lin_r;
      REG_OFF:  prdata = off_r;
      REG_UNIT: prdata = {{(DATA_W-1){1'b0}}, unit_r};
      default:  prdata = '0;
    endcase
  end

  // the pipeline moves whenever the output buffer has room
  assign en = !full_r;
  assign in_chan.ready = en;

  dqc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_chan.valid),
    .smp    (in_chan.depth_sample),
    .last   (in_chan.last_in),
    .quad   (quad_r),
    .lin    (lin_r),
    .off    (off_r),
    .unit   (unit_r),
    .v_o    (sq_v[0]),
    .side_o (sq_side[0]),
    .sq_o   (sq_bus[0])
  );

  // square root cells
  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    dqc_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[i]),
      .side_i (sq_side[i]),
      .sq_i   (sq_bus[i]),
      .v_o    (sq_v[i+1]),
      .side_o (sq_side[i+1]),
      .sq_o   (sq_bus[i+1])
    );
  end

  // numerator s - b with sign, then root sign and saturation checks
  always_comb begin
    s_ext = {1'b0, sq_bus[SQRT_CELLS].root};
    b_ext = {{(NUM_W-COEF_W){1'b0}}, sq_side[SQRT_CELLS].bm};
    pside = sq_side[SQRT_CELLS];
    if (pside.bn) begin
      nval = s_ext + b_ext;
      nneg = 1'b0;
    end else if (s_ext >= b_ext) begin
      nval = s_ext - b_ext;
      nneg = 1'b0;
    end else begin
      nval = b_ext - s_ext;
      nneg = 1'b1;
    end
    sat_lim = {pside.am, {(QUO_W+1){1'b0}}};
    if (pside.kind == KIND_ROOT) begin
      if (nval == '0 || nneg != pside.an) begin
        pside.kind = KIND_ZERO;
      end else if ({{(SAT_W-NUM_W){1'b0}}, nval} >= sat_lim) begin
        pside.kind = KIND_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sq_v[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pside_r    <= pside;
      pdiv_r.num <= nval;
      pdiv_r.dsh <= {pside.am, {QUO_W{1'b0}}};
      pdiv_r.quo <= '0;
    end
  end

  assign dv_v[0]    = pv_r;
  assign dv_side[0] = pside_r;
  assign dv_bus[0]  = pdiv_r;

  // division cells
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    dqc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[k]),
      .side_i (dv_side[k]),
      .dv_i   (dv_bus[k]),
      .v_o    (dv_v[k+1]),
      .side_o (dv_side[k+1]),
      .dv_o   (dv_bus[k+1])
    );
  end

  // pick the result, scale by ten in the fine unit and saturate
  always_comb begin
    case (dv_side[DIV_CELLS].kind)
      KIND_ROOT: res16 = dv_bus[DIV_CELLS].quo;
      KIND_ZERO: res16 = '0;
      KIND_PASS: res16 = {{(RES_W-IDX_W){1'b0}}, dv_side[DIV_CELLS].d};
      KIND_SAT:  res16 = '1;
      default:   res16 = '0;
    endcase
    res10 = {1'b0, res16, 3'b000} + {3'b000, res16, 1'b0};
    if (!unit_r) begin
      res_fin = res16;
    end else if (res10 > {{(MUL10_W-RES_W){1'b0}}, {RES_W{1'b1}}}) begin
      res_fin = '1;
    end else begin
      res_fin = res10[RES_W-1:0];
    end
  end

  // two-entry output buffer
  assign push = en && dv_v[DIV_CELLS];
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      full_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_r + {1'b0, push} - {1'b0, pop};
      full_r <= (cnt_r + {1'b0, push} - {1'b0, pop}) == 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0: begin
        if (push) begin
          d0_r <= res_fin;
          l0_r <= dv_side[DIV_CELLS].last;
        end
      end
      2'd1: begin
        if (push && pop) begin
          d0_r <= res_fin;
          l0_r <= dv_side[DIV_CELLS].last;
        end else if (push) begin
          d1_r <= res_fin;
          l1_r <= dv_side[DIV_CELLS].last;
        end
      end
      2'd2: begin
        if (pop) begin
          d0_r <= d1_r;
          l0_r <= l1_r;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid           = (cnt_r != 2'd0);
  assign out_chan.corrected_depth = d0_r;
  assign out_chan.last_out        = l0_r;

  // buffer never overflows its two entries
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  // a result only arrives when there is room for it
  assert property (@(posedge clk) disable iff (!rst_n) push |-> cnt_r != 2'd2)
    else $error("result pushed into full buffer");

  // full flag tracks the count
  assert property (@(posedge clk) disable iff (!rst_n) full_r == (cnt_r == 2'd2))
    else $error("full flag out of step with count");

  // a held pipeline keeps the valid flag at its end
  assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(dv_v[DIV_CELLS]))
    else $error("pipeline moved while held");

endmodule
